[design/scfp_pkg.sv]
// Package for the four-point sphere center core.
// Holds the coordinate and datapath widths and the beat types of both channels
// and of the front-to-back queue. No dependencies.
package scfp_pkg;

    localparam int COORD_BITS = 24;
    localparam int OUT_W      = 32;
    localparam int QB         = OUT_W + 1;

    localparam int A_W   = COORD_BITS + 2;
    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int B_W   = 2 * COORD_BITS + 1;
    localparam int PP_W  = 2 * A_W;
    localparam int C_W   = PP_W + 1;
    localparam int LO_W  = (C_W + 1) / 2;
    localparam int XH_W  = B_W - LO_W;
    localparam int YH_W  = C_W - LO_W;
    localparam int HH_W  = XH_W + YH_W;
    localparam int HL_W  = XH_W + LO_W + 1;
    localparam int LH_W  = LO_W + 1 + YH_W;
    localparam int LL_W  = 2 * LO_W;
    localparam int PR_W  = B_W + C_W;
    localparam int N_W   = PR_W + 2;
    localparam int DIV_W = N_W + 1 + QB;

    localparam int BK_STAGES = 5 + QB;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] p1_x;
        logic signed [COORD_BITS-1:0] p1_y;
        logic signed [COORD_BITS-1:0] p1_z;
        logic signed [COORD_BITS-1:0] p2_x;
        logic signed [COORD_BITS-1:0] p2_y;
        logic signed [COORD_BITS-1:0] p2_z;
        logic signed [COORD_BITS-1:0] p3_x;
        logic signed [COORD_BITS-1:0] p3_y;
        logic signed [COORD_BITS-1:0] p3_z;
        logic signed [COORD_BITS-1:0] p4_x;
        logic signed [COORD_BITS-1:0] p4_y;
        logic signed [COORD_BITS-1:0] p4_z;
    } in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] center_x;
        logic signed [OUT_W-1:0] center_y;
        logic signed [OUT_W-1:0] center_z;
        logic                    singular;
    } out_t;

    typedef struct packed {
        logic [2:0][A_W-1:0]      acol;
        logic [2:0][B_W-1:0]      b;
        logic [2:0][2:0][C_W-1:0] cof;
    } mid_t;

endpackage

[design/scfp_front.sv]
// Front part of the sphere center core: accepts point beats and builds the
// linear system (column 0, right-hand side, cofactors). Depends on scfp_pkg.
module scfp_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  scfp_pkg::in_t s_item,
    input  logic          q_full,
    output logic          push,
    output scfp_pkg::mid_t mid
);

    function automatic int other_lo(input int i);
        return (i == 0) ? 1 : 0;
    endfunction

    function automatic int other_hi(input int i);
        return (i == 2) ? 1 : 2;
    endfunction

    logic signed [scfp_pkg::COORD_BITS-1:0] p [4][3];
    logic signed [scfp_pkg::A_W-1:0]        dif [3][3];

    logic [2:0] vld_reg;
    logic       en;

    logic signed [scfp_pkg::A_W-1:0]  a1_reg [3][3];
    logic signed [scfp_pkg::SQ_W-1:0] sq1_reg [4][3];

    logic signed [scfp_pkg::A_W-1:0]  a2_reg [3];
    logic signed [scfp_pkg::B_W-1:0]  nrm [4];
    logic signed [scfp_pkg::B_W-1:0]  b2_reg [3];
    logic signed [scfp_pkg::PP_W-1:0] pa2_reg [3][3];
    logic signed [scfp_pkg::PP_W-1:0] pb2_reg [3][3];

    logic signed [scfp_pkg::A_W-1:0] a3_reg [3];
    logic signed [scfp_pkg::B_W-1:0] b3_reg [3];
    logic signed [scfp_pkg::C_W-1:0] cof3_reg [3][3];

    assign en      = !vld_reg[2] || !q_full;
    assign s_ready = en;
    assign push    = vld_reg[2] && !q_full;

    always_comb begin
        p[0][0] = s_item.p1_x; p[0][1] = s_item.p1_y; p[0][2] = s_item.p1_z;
        p[1][0] = s_item.p2_x; p[1][1] = s_item.p2_y; p[1][2] = s_item.p2_z;
        p[2][0] = s_item.p3_x; p[2][1] = s_item.p3_y; p[2][2] = s_item.p3_z;
        p[3][0] = s_item.p4_x; p[3][1] = s_item.p4_y; p[3][2] = s_item.p4_z;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                dif[i][j] = scfp_pkg::A_W'(p[i+1][j]) - scfp_pkg::A_W'(p[i][j]);
            end
        end
        for (int i = 0; i < 4; i++) begin
            nrm[i] = scfp_pkg::B_W'(sq1_reg[i][0]) + scfp_pkg::B_W'(sq1_reg[i][1])
                   + scfp_pkg::B_W'(sq1_reg[i][2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    a1_reg[i][j] <= dif[i][j] + dif[i][j];
                end
            end
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 3; j++) begin
                    sq1_reg[i][j] <= p[i][j] * p[i][j];
                end
            end
            for (int i = 0; i < 3; i++) begin
                a2_reg[i] <= a1_reg[i][0];
                b2_reg[i] <= nrm[i+1] - nrm[i];
                for (int k = 0; k < 3; k++) begin
                    pa2_reg[i][k] <= a1_reg[other_lo(i)][other_lo(k)]
                                   * a1_reg[other_hi(i)][other_hi(k)];
                    pb2_reg[i][k] <= a1_reg[other_lo(i)][other_hi(k)]
                                   * a1_reg[other_hi(i)][other_lo(k)];
                end
            end
            for (int i = 0; i < 3; i++) begin
                a3_reg[i] <= a2_reg[i];
                b3_reg[i] <= b2_reg[i];
                for (int k = 0; k < 3; k++) begin
                    if (((i + k) & 1) == 1) begin
                        cof3_reg[i][k] <= scfp_pkg::C_W'(pb2_reg[i][k])
                                        - scfp_pkg::C_W'(pa2_reg[i][k]);
                    end else begin
                        cof3_reg[i][k] <= scfp_pkg::C_W'(pa2_reg[i][k])
                                        - scfp_pkg::C_W'(pb2_reg[i][k]);
                    end
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mid.acol[i] = a3_reg[i];
            mid.b[i]    = b3_reg[i];
            for (int k = 0; k < 3; k++) begin
                mid.cof[i][k] = cof3_reg[i][k];
            end
        end
    end

endmodule

[design/scfp_queue.sv]
// Short queue between the front and back parts of the sphere center core.
// Flip-flop storage of scfp_pkg::mid_t beats. Depends on scfp_pkg.
module scfp_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  scfp_pkg::mid_t wdata,
    input  logic           pop,
    output scfp_pkg::mid_t rdata,
    output logic           full,
    output logic           empty
);

    scfp_pkg::mid_t                  mem_reg [scfp_pkg::QDEPTH];
    logic [scfp_pkg::QPTR_W-1:0]     wr_reg;
    logic [scfp_pkg::QPTR_W-1:0]     rd_reg;
    logic [scfp_pkg::QCNT_W-1:0]     cnt_reg;
    logic [scfp_pkg::QCNT_W-1:0]     cnt_next;

    assign full     = cnt_reg == scfp_pkg::QCNT_W'(scfp_pkg::QDEPTH);
    assign empty    = cnt_reg == '0;
    assign rdata    = mem_reg[rd_reg];
    assign cnt_next = cnt_reg + scfp_pkg::QCNT_W'(push) - scfp_pkg::QCNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= wdata;
        end
    end

endmodule

[design/scfp_back.sv]
// Back part of the sphere center core: determinants by cofactor expansion,
// then a pipelined restoring divider with rounding and saturation. Depends on scfp_pkg.
module scfp_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_empty,
    input  scfp_pkg::mid_t q_rdata,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output scfp_pkg::out_t m_item
);

    function automatic logic [scfp_pkg::OUT_W-1:0] round_out(
        input logic [scfp_pkg::QB-1:0] q,
        input logic                    sat,
        input logic                    neg
    );
        logic [scfp_pkg::OUT_W-1:0] r;
        logic                       over;
        if (!neg) begin
            over = sat || q[scfp_pkg::QB-1] || q[scfp_pkg::OUT_W-1];
            r = over ? {1'b0, {(scfp_pkg::OUT_W-1){1'b1}}} : q[scfp_pkg::OUT_W-1:0];
        end else begin
            over = sat || q[scfp_pkg::QB-1]
                || (q[scfp_pkg::OUT_W-1] && (q[scfp_pkg::OUT_W-2:0] != '0));
            r = over ? {1'b1, {(scfp_pkg::OUT_W-1){1'b0}}}
                     : (~q[scfp_pkg::OUT_W-1:0] + 1'b1);
        end
        return r;
    endfunction

    logic          en;
    logic [scfp_pkg::BK_STAGES-1:0] vld_reg;
    logic          m_valid_reg;
    scfp_pkg::out_t m_item_reg;

    logic signed [scfp_pkg::B_W-1:0] xop [4][3];
    logic signed [scfp_pkg::C_W-1:0] yop [4][3];

    logic signed [scfp_pkg::HH_W-1:0] hh_reg [4][3];
    logic signed [scfp_pkg::HL_W-1:0] hl_reg [4][3];
    logic signed [scfp_pkg::LH_W-1:0] lh_reg [4][3];
    logic        [scfp_pkg::LL_W-1:0] ll_reg [4][3];

    logic signed [scfp_pkg::PR_W-1:0] prod_reg [4][3];
    logic signed [scfp_pkg::N_W-1:0]  det_reg [4];

    logic [scfp_pkg::N_W-1:0] ad_reg;
    logic [scfp_pkg::N_W-1:0] an_reg [3];
    logic                     neg4_reg [3];
    logic                     sng4_reg;

    logic [scfp_pkg::DIV_W-1:0] top [3];
    logic [scfp_pkg::DIV_W-1:0] bot_lim;

    logic [scfp_pkg::DIV_W-1:0] rem_reg [scfp_pkg::QB+1][3];
    logic [scfp_pkg::QB-1:0]    q_reg   [scfp_pkg::QB+1][3];
    logic                       neg_reg [scfp_pkg::QB+1][3];
    logic                       sat_reg [scfp_pkg::QB+1][3];
    logic [scfp_pkg::N_W:0]     bot_reg [scfp_pkg::QB+1];
    logic                       sng_reg [scfp_pkg::QB+1];

    logic [scfp_pkg::DIV_W-1:0] sub_ref [scfp_pkg::QB][3];
    logic                       ge      [scfp_pkg::QB][3];

    assign en      = !m_valid_reg || m_ready;
    assign pop     = en && !q_empty;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_comb begin
        for (int t = 0; t < 4; t++) begin
            for (int i = 0; i < 3; i++) begin
                if (t == 0) begin
                    xop[t][i] = scfp_pkg::B_W'($signed(q_rdata.acol[i]));
                    yop[t][i] = $signed(q_rdata.cof[i][0]);
                end else begin
                    xop[t][i] = $signed(q_rdata.b[i]);
                    yop[t][i] = $signed(q_rdata.cof[i][(t == 0) ? 0 : t - 1]);
                end
            end
        end
        bot_lim = scfp_pkg::DIV_W'({ad_reg, 1'b0}) << scfp_pkg::QB;
        for (int k = 0; k < 3; k++) begin
            top[k] = scfp_pkg::DIV_W'({an_reg[k], 1'b0}) + scfp_pkg::DIV_W'(ad_reg);
        end
        for (int s = 0; s < scfp_pkg::QB; s++) begin
            for (int k = 0; k < 3; k++) begin
                sub_ref[s][k] = scfp_pkg::DIV_W'(bot_reg[s]) << (scfp_pkg::QB - 1 - s);
                ge[s][k]      = rem_reg[s][k] >= sub_ref[s][k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[scfp_pkg::BK_STAGES-2:0], !q_empty};
            m_valid_reg <= vld_reg[scfp_pkg::BK_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int t = 0; t < 4; t++) begin
                for (int i = 0; i < 3; i++) begin
                    hh_reg[t][i] <= $signed(xop[t][i][scfp_pkg::B_W-1:scfp_pkg::LO_W])
                                  * $signed(yop[t][i][scfp_pkg::C_W-1:scfp_pkg::LO_W]);
                    hl_reg[t][i] <= $signed(xop[t][i][scfp_pkg::B_W-1:scfp_pkg::LO_W])
                                  * $signed({1'b0, yop[t][i][scfp_pkg::LO_W-1:0]});
                    lh_reg[t][i] <= $signed({1'b0, xop[t][i][scfp_pkg::LO_W-1:0]})
                                  * $signed(yop[t][i][scfp_pkg::C_W-1:scfp_pkg::LO_W]);
                    ll_reg[t][i] <= xop[t][i][scfp_pkg::LO_W-1:0]
                                  * yop[t][i][scfp_pkg::LO_W-1:0];
                    prod_reg[t][i] <= (scfp_pkg::PR_W'(hh_reg[t][i]) << (2 * scfp_pkg::LO_W))
                                    + ((scfp_pkg::PR_W'(hl_reg[t][i])
                                      + scfp_pkg::PR_W'(lh_reg[t][i])) << scfp_pkg::LO_W)
                                    + scfp_pkg::PR_W'(ll_reg[t][i]);
                end
                det_reg[t] <= scfp_pkg::N_W'(prod_reg[t][0]) + scfp_pkg::N_W'(prod_reg[t][1])
                            + scfp_pkg::N_W'(prod_reg[t][2]);
            end

            ad_reg   <= det_reg[0][scfp_pkg::N_W-1] ? -det_reg[0] : det_reg[0];
            sng4_reg <= det_reg[0] == '0;
            for (int k = 0; k < 3; k++) begin
                an_reg[k]   <= det_reg[k+1][scfp_pkg::N_W-1] ? -det_reg[k+1] : det_reg[k+1];
                neg4_reg[k] <= det_reg[k+1][scfp_pkg::N_W-1] ^ det_reg[0][scfp_pkg::N_W-1];
            end

            bot_reg[0] <= {ad_reg, 1'b0};
            sng_reg[0] <= sng4_reg;
            for (int k = 0; k < 3; k++) begin
                rem_reg[0][k] <= top[k];
                q_reg[0][k]   <= '0;
                neg_reg[0][k] <= neg4_reg[k];
                sat_reg[0][k] <= top[k] >= bot_lim;
            end

            for (int s = 0; s < scfp_pkg::QB; s++) begin
                bot_reg[s+1] <= bot_reg[s];
                sng_reg[s+1] <= sng_reg[s];
                for (int k = 0; k < 3; k++) begin
                    rem_reg[s+1][k] <= ge[s][k] ? rem_reg[s][k] - sub_ref[s][k]
                                                : rem_reg[s][k];
                    q_reg[s+1][k]   <= {q_reg[s][k][scfp_pkg::QB-2:0], ge[s][k]};
                    neg_reg[s+1][k] <= neg_reg[s][k];
                    sat_reg[s+1][k] <= sat_reg[s][k];
                end
            end

            if (sng_reg[scfp_pkg::QB]) begin
                m_item_reg.center_x <= '0;
                m_item_reg.center_y <= '0;
                m_item_reg.center_z <= '0;
                m_item_reg.singular <= 1'b1;
            end else begin
                m_item_reg.center_x <= round_out(q_reg[scfp_pkg::QB][0],
                    sat_reg[scfp_pkg::QB][0], neg_reg[scfp_pkg::QB][0]);
                m_item_reg.center_y <= round_out(q_reg[scfp_pkg::QB][1],
                    sat_reg[scfp_pkg::QB][1], neg_reg[scfp_pkg::QB][1]);
                m_item_reg.center_z <= round_out(q_reg[scfp_pkg::QB][2],
                    sat_reg[scfp_pkg::QB][2], neg_reg[scfp_pkg::QB][2]);
                m_item_reg.singular <= 1'b0;
            end
        end
    end

endmodule

[design/sphere_center_four_points_core.sv]
// Sphere center of four 3-D points: one point-set beat in, one center beat out.
// Takes one beat per cycle when neither side stalls; a beat passes the front registers,
// the queue and the back pipeline (five determinant stages, the 33-stage
// restoring divider that sets the depth, and the output register). The center is
// rounded to nearest with ties away from zero and saturated to 32 bits; coplanar or
// repeated points give singular = 1 and zero coordinates.
module sphere_center_four_points_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  scfp_pkg::in_t  s_item,
    output logic           m_valid,
    input  logic           m_ready,
    output scfp_pkg::out_t m_item
);

    scfp_pkg::mid_t fr_mid;
    scfp_pkg::mid_t q_rdata;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;

    scfp_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_full  (q_full),
        .push    (push),
        .mid     (fr_mid)
    );

    scfp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wdata   (fr_mid),
        .pop     (pop),
        .rdata   (q_rdata),
        .full    (q_full),
        .empty   (q_empty)
    );

    scfp_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_rdata (q_rdata),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

[bench/tb_sphere_center_four_points_core.sv]
// Testbench for sphere_center_four_points_core: directed and random point sets,
// an exact wide-integer center predictor and an in-order result checker.
// Depends on scfp_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_sphere_center_four_points_core;

    typedef logic signed [191:0] wide_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 120;
    localparam int RANDOM_ITEMS   = 1425;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    scfp_pkg::in_t  s_item = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    scfp_pkg::out_t m_item;

    scfp_pkg::in_t  pending_sets[$];
    scfp_pkg::out_t expected_centers[$];
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    bit   send_hold = 1'b0;
    int   mismatches = 0;
    int   sets_sent = 0;
    int   singular_seen = 0;
    int   saturated_seen = 0;
    int   quiet_cycles = 0;

    always #10 aclk = ~aclk;

    sphere_center_four_points_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    function automatic wide_t det3(wide_t m[3][3]);
        return m[0][0] * m[1][1] * m[2][2] + m[0][1] * m[1][2] * m[2][0]
             + m[0][2] * m[1][0] * m[2][1] - m[0][0] * m[1][2] * m[2][1]
             - m[0][1] * m[1][0] * m[2][2] - m[0][2] * m[1][1] * m[2][0];
    endfunction

    function automatic logic [31:0] round_div_sat(wide_t num, wide_t den);
        bit    neg;
        wide_t an, ad, q;
        neg = (num < 0) != (den < 0);
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        q = (2 * an + ad) / (2 * ad);
        if (!neg)
            return (q > 192'sd2147483647) ? 32'h7FFF_FFFF : q[31:0];
        if (q > 192'sd2147483648)
            return 32'h8000_0000;
        return -q[31:0];
    endfunction

    function automatic scfp_pkg::out_t sphere_center(scfp_pkg::in_t it);
        wide_t pt[4][3];
        wide_t nrm[4];
        wide_t a[3][3];
        wide_t m[3][3];
        wide_t rhs[3];
        wide_t d;
        scfp_pkg::out_t r;
        pt[0] = '{it.p1_x, it.p1_y, it.p1_z};
        pt[1] = '{it.p2_x, it.p2_y, it.p2_z};
        pt[2] = '{it.p3_x, it.p3_y, it.p3_z};
        pt[3] = '{it.p4_x, it.p4_y, it.p4_z};
        for (int i = 0; i < 4; i++)
            nrm[i] = pt[i][0] * pt[i][0] + pt[i][1] * pt[i][1] + pt[i][2] * pt[i][2];
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++)
                a[i][j] = 2 * (pt[i + 1][j] - pt[i][j]);
            rhs[i] = nrm[i + 1] - nrm[i];
        end
        d = det3(a);
        r = '0;
        if (d == 0) begin
            r.singular = 1'b1;
            return r;
        end
        m = a;
        for (int i = 0; i < 3; i++) m[i][0] = rhs[i];
        r.center_x = round_div_sat(det3(m), d);
        m = a;
        for (int i = 0; i < 3; i++) m[i][1] = rhs[i];
        r.center_y = round_div_sat(det3(m), d);
        m = a;
        for (int i = 0; i < 3; i++) m[i][2] = rhs[i];
        r.center_z = round_div_sat(det3(m), d);
        return r;
    endfunction

    function automatic scfp_pkg::in_t make_set(int x1, int y1, int z1, int x2, int y2,
                                               int z2, int x3, int y3, int z3, int x4,
                                               int y4, int z4);
        scfp_pkg::in_t it;
        it.p1_x = scfp_pkg::COORD_BITS'(x1);
        it.p1_y = scfp_pkg::COORD_BITS'(y1);
        it.p1_z = scfp_pkg::COORD_BITS'(z1);
        it.p2_x = scfp_pkg::COORD_BITS'(x2);
        it.p2_y = scfp_pkg::COORD_BITS'(y2);
        it.p2_z = scfp_pkg::COORD_BITS'(z2);
        it.p3_x = scfp_pkg::COORD_BITS'(x3);
        it.p3_y = scfp_pkg::COORD_BITS'(y3);
        it.p3_z = scfp_pkg::COORD_BITS'(z3);
        it.p4_x = scfp_pkg::COORD_BITS'(x4);
        it.p4_y = scfp_pkg::COORD_BITS'(y4);
        it.p4_z = scfp_pkg::COORD_BITS'(z4);
        return it;
    endfunction

    function automatic logic signed [scfp_pkg::COORD_BITS-1:0] rand_coord(bit narrow);
        if (narrow)
            return scfp_pkg::COORD_BITS'(int'($urandom_range(0, 4000)) - 2000);
        return scfp_pkg::COORD_BITS'($urandom());
    endfunction

    function automatic scfp_pkg::in_t random_set();
        scfp_pkg::in_t it;
        int  kind;
        bit  narrow;
        kind = $urandom_range(0, 99);
        narrow = (kind < 35);
        it.p1_x = rand_coord(narrow); it.p1_y = rand_coord(narrow);
        it.p1_z = rand_coord(narrow);
        it.p2_x = rand_coord(narrow); it.p2_y = rand_coord(narrow);
        it.p2_z = rand_coord(narrow);
        it.p3_x = rand_coord(narrow); it.p3_y = rand_coord(narrow);
        it.p3_z = rand_coord(narrow);
        it.p4_x = rand_coord(narrow); it.p4_y = rand_coord(narrow);
        it.p4_z = rand_coord(narrow);
        if (kind >= 85 && kind < 92) begin
            it.p2_z = it.p1_z; it.p3_z = it.p1_z; it.p4_z = it.p1_z;
        end else if (kind >= 92) begin
            it.p3_x = it.p2_x; it.p3_y = it.p2_y; it.p3_z = it.p2_z;
        end
        return it;
    endfunction

    // driver: hold the beat until accepted, then advance
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_centers.push_back(sphere_center(s_item));
                sets_sent++;
            end
            if (!s_valid || s_ready) begin
                if (pending_sets.size() > 0 && !send_hold
                        && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_item  <= pending_sets.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each center beat with the oldest expectation
    always @(posedge aclk) begin
        scfp_pkg::out_t exp_c;
        if (aresetn) begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (m_valid && m_ready) begin
                if (expected_centers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected center beat %p", m_item);
                end else begin
                    exp_c = expected_centers.pop_front();
                    if (exp_c.singular)
                        singular_seen++;
                    if (exp_c.center_x == 32'h7FFF_FFFF || exp_c.center_x == 32'h8000_0000
                            || exp_c.center_y == 32'h7FFF_FFFF
                            || exp_c.center_y == 32'h8000_0000
                            || exp_c.center_z == 32'h7FFF_FFFF
                            || exp_c.center_z == 32'h8000_0000)
                        saturated_seen++;
                    if (m_item !== exp_c) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("center mismatch: expected %p, got %p", exp_c, m_item);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else if (aresetn)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d centers outstanding",
                     expected_centers.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        pending_sets.push_back(make_set(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1));
        pending_sets.push_back(make_set(0, 0, 0, -1, 0, 0, 0, -1, 0, 0, 0, -1));
        pending_sets.push_back(make_set(100, 0, 0, -100, 0, 0, 0, 100, 0, 0, 0, 100));
        pending_sets.push_back(make_set(-8388608, 0, 0, 8388607, 0, 0,
                                        0, 8388607, 0, 0, 0, 1));
        pending_sets.push_back(make_set(-8388608, 0, 0, 8388607, 0, 0,
                                        0, 8388607, 0, 0, 0, -1));
        pending_sets.push_back(make_set(0, -8388608, 0, 0, 8388607, 0,
                                        1, 0, 0, 8388607, 0, 0));
        pending_sets.push_back(make_set(-8388608, -8388608, -8388608, 8388607, -8388608,
                                        -8388608, -8388608, 8388607, -8388608,
                                        -8388608, -8388608, 8388607));
        pending_sets.push_back(make_set(8388607, 8388607, 8388607, -8388608, 8388607,
                                        8388607, 8388607, -8388608, 8388607,
                                        8388607, 8388607, -8388608));
        pending_sets.push_back(make_set(1, 2, 3, 1, 2, 3, 4, 5, 6, 7, 8, 9));
        pending_sets.push_back(make_set(0, 0, 5, 9, 0, 5, 0, 9, 5, 7, 7, 5));
        pending_sets.push_back(make_set(0, 0, 0, 1, 1, 1, 2, 2, 2, 3, 3, 3));
        pending_sets.push_back(make_set(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_sets.push_back(make_set(-8388608, -8388608, -8388608, -8388608,
                                        -8388608, -8388608, 8388607, 8388607, 8388607,
                                        1, 2, 3));
        pending_sets.push_back(make_set(3, 0, 0, 0, 3, 0, 0, 0, 3, -3, 0, 0));
        pending_sets.push_back(make_set(0, 0, 0, 3, 0, 0, 0, 1, 0, 0, 0, 1));
        pending_sets.push_back(make_set(-1, 0, 0, -4, 0, 0, 0, -1, 0, 0, 0, -1));

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 76 : 0;
            recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 13 : 0;
            for (int i = 0; i < RANDOM_ITEMS / 3; i++)
                pending_sets.push_back(random_set());
            while (pending_sets.size() > 0 || s_valid)
                @(posedge aclk);
            if (phase == 0) begin
                send_hold = 1'b1;
                while (expected_centers.size() > 0)
                    @(posedge aclk);
                send_hold = 1'b0;
            end
        end

        while (expected_centers.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d point sets: %0d coplanar or repeated, %0d with a saturated center",
                 sets_sent, singular_seen, saturated_seen);
        $display("three stall mixes on both channels, one full drain before resuming");
        if (mismatches == 0 && expected_centers.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
